@@ rtl/tlvd_pkg.sv @@
// Shared types, constants and helpers for the radar TLV packet deframer.
`default_nettype none

package tlvd_pkg;

  localparam logic [63:0] SYNC_WORD_RST = 64'h0708_0506_0304_0102;
  localparam logic [15:0] MAX_LEN_RST   = 16'd4096;
  localparam logic [31:0] MIN_PACKET    = 32'd40;
  localparam logic [31:0] TLV_HDR_BYTES = 32'd8;

  localparam logic [31:0] TYPE_POINT_CLOUD = 32'd1020;
  localparam logic [31:0] TYPE_OBJ_LIST    = 32'd1010;
  localparam logic [31:0] TYPE_INDEX       = 32'd1011;
  localparam logic [31:0] TYPE_PRESENCE    = 32'd1021;

  localparam logic [2:0] HDR_LENGTH = 3'd1;
  localparam logic [2:0] HDR_TLVS   = 3'd6;
  localparam logic [2:0] HDR_LAST   = 3'd7;
  localparam logic [2:0] TLV_TYPE_LAST = 3'd3;
  localparam logic [2:0] TLV_LEN_LAST  = 3'd7;

  localparam logic [0:0] REG_SYNC    = 1'b0;
  localparam logic [0:0] REG_MAX_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PAY = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_HDR_OVR = 2'd2,
    ST_PAY_OVR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_POINT_CLOUD = 3'd0,
    CLS_OBJ_LIST    = 3'd1,
    CLS_INDEX       = 3'd2,
    CLS_PRESENCE    = 3'd3,
    CLS_UNKNOWN     = 3'd4
  } tlv_class_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_TLV_HDR = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  typedef struct packed {
    kind_t         kind;
    logic [31:0]   value;
    logic [2:0]    header_field;
    tlv_class_t    tlv_class;
    logic [7:0]    tlv_number;
    logic [15:0]   payload_offset;
    logic          last_of_tlv;
    logic          packet_end;
    status_t       status;
  } res_t;

  function automatic tlv_class_t classify(input logic [31:0] tlv_type);
    tlv_class_t c;
    priority if (tlv_type == TYPE_POINT_CLOUD) c = CLS_POINT_CLOUD;
    else if (tlv_type == TYPE_OBJ_LIST) c = CLS_OBJ_LIST;
    else if (tlv_type == TYPE_INDEX) c = CLS_INDEX;
    else if (tlv_type == TYPE_PRESENCE) c = CLS_PRESENCE;
    else c = CLS_UNKNOWN;
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/radar_tlv_packet_deframer.sv @@
// Top level of the radar TLV packet deframer.
// Takes one received byte per transfer and sustains one byte per clock: the parse
// engine retires one byte each cycle unless the output queue is full. A byte's path
// to its result is the input queue, then an engine step into the output queue. Bytes
// that close nothing give no result. A two-entry queue on each side of the engine
// lets the input flow on while a result waits on out_ready, until both queues fill.
// Registers: sync word at byte address 0 (64 bits, first received byte in bits 7:0)
// and maximum packet length at byte address 8 (16 bits); write them only while idle.
`default_nettype none

module radar_tlv_packet_deframer
  import tlvd_pkg::*;
#(
  parameter int LENGTH_WIDTH    = 16,
  parameter int TLV_COUNT_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_value,
  output logic [2:0]       out_header_field,
  output logic [2:0]       out_tlv_class,
  output logic [7:0]       out_tlv_number,
  output logic [15:0]      out_payload_offset,
  output logic             out_last_of_tlv,
  output logic             out_packet_end,
  output logic [1:0]       out_status
);

  logic [63:0] sync_r;
  logic [15:0] max_len_r;
  logic        cfg_wr;

  logic        q_valid, q_ready;
  logic [7:0]  q_byte;
  logic        r_valid, r_ready;
  res_t        r_res, o_res;
  logic [$bits(res_t)-1:0] o_bits;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_MAX_LEN) ? {48'd0, max_len_r} : sync_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= SYNC_WORD_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        REG_SYNC:    sync_r    <= cfg_pwdata;
        REG_MAX_LEN: max_len_r <= cfg_pwdata[15:0];
        default:     sync_r    <= sync_r;
      endcase
    end
  end

  tlvd_fifo #(.WIDTH(8)) u_in_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (in_rx_byte),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_byte)
  );

  tlvd_engine #(
    .LENGTH_WIDTH    (LENGTH_WIDTH),
    .TLV_COUNT_WIDTH (TLV_COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .sync_word  (sync_r),
    .max_len    (max_len_r),
    .byte_valid (q_valid),
    .byte_ready (q_ready),
    .byte_data  (q_byte),
    .res_valid  (r_valid),
    .res_ready  (r_ready),
    .res        (r_res)
  );

  tlvd_fifo #(.WIDTH($bits(res_t))) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (r_valid),
    .wr_ready (r_ready),
    .wr_data  (r_res),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (o_bits)
  );

  assign o_res              = o_bits;
  assign out_kind           = o_res.kind;
  assign out_value          = o_res.value;
  assign out_header_field   = o_res.header_field;
  assign out_tlv_class      = o_res.tlv_class;
  assign out_tlv_number     = o_res.tlv_number;
  assign out_payload_offset = o_res.payload_offset;
  assign out_last_of_tlv    = o_res.last_of_tlv;
  assign out_packet_end     = o_res.packet_end;
  assign out_status         = o_res.status;

endmodule

`default_nettype wire

@@ rtl/tlvd_fifo.sv @@
// Two-entry queue with registered storage, used on both sides of the parse engine.
`default_nettype none

module tlvd_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       count_r;
  logic             wr_fire, rd_fire;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (wr_fire) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_fire) begin
        rptr_r <= ~rptr_r;
      end
      unique case ({wr_fire, rd_fire})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/tlvd_engine.sv @@
// Byte-serial parse engine: sync hunt, header words, TLV walk and packet close.
`default_nettype none

module tlvd_engine
  import tlvd_pkg::*;
#(
  parameter int LENGTH_WIDTH    = 16,
  parameter int TLV_COUNT_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [63:0] sync_word,
  input  wire logic [15:0] max_len,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire logic [7:0]  byte_data,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res
);

  localparam int LW = LENGTH_WIDTH;
  localparam int TW = TLV_COUNT_WIDTH;

  phase_t          phase_r, phase_nxt;
  logic [63:0]     recent_r, recent_nxt;
  logic [LW-1:0]   pcount_r, pcount_nxt;
  logic [LW-1:0]   plen_r, plen_nxt;
  logic [31:0]     wasm_r, wasm_nxt;
  logic [2:0]      hwc_r, hwc_nxt;
  logic [31:0]     total_r, total_nxt;
  logic [TW-1:0]   cnt_r, cnt_nxt;
  tlv_class_t      cls_r, cls_nxt;
  logic [31:0]     remain_r, remain_nxt;
  status_t         err_r, err_nxt;

  logic            step;
  logic            res_v;
  logic [LW-1:0]   pc_inc;
  logic [31:0]     wa_shift;
  logic [63:0]     recent_shift;
  logic [LW-1:0]   hunt_cnt;
  logic            sync_hit;
  logic            hdr_word_done;
  logic            len_bad;
  logic            end_hit;
  logic [TW-1:0]   cnt_inc;
  logic [TW-1:0]   cnt_begin;
  logic            all_done;
  logic            hdr_overrun;
  logic            begin_overrun;
  phase_t          begin_phase;
  logic [LW-1:0]   room;
  logic [31:0]     tlv_body;
  logic            tlvh_bad;
  logic            tlvh_zero;
  logic [31:0]     pay_rem_dec;
  logic            pay_fin;

  assign byte_ready = res_ready;
  assign step       = byte_valid && res_ready;
  assign res_valid  = step && res_v;

  assign pc_inc        = pcount_r + LW'(1);
  assign wa_shift      = {byte_data, wasm_r[31:8]};
  assign recent_shift  = {byte_data, recent_r[63:8]};
  assign hunt_cnt      = (pcount_r < LW'(8)) ? pcount_r + LW'(1) : pcount_r;
  assign sync_hit      = (hunt_cnt >= LW'(8)) && (recent_shift == sync_word);
  assign hdr_word_done = (pc_inc[1:0] == 2'd0);
  assign len_bad       = (wa_shift < MIN_PACKET) || (wa_shift > 32'(max_len)) ||
                         ((wa_shift >> LW) != 32'd0);
  assign end_hit       = (pc_inc >= plen_r);

  assign cnt_inc       = (cnt_r == '1) ? cnt_r : cnt_r + TW'(1);
  assign cnt_begin     = (phase_r == PH_HEADER) ? cnt_r : cnt_inc;
  assign all_done      = (32'(cnt_begin) == total_r);
  assign hdr_overrun   = ({1'b0, pc_inc} + (LW+1)'(TLV_HDR_BYTES)) > {1'b0, plen_r};
  assign begin_overrun = !all_done && hdr_overrun;
  assign begin_phase   = (all_done || hdr_overrun) ? PH_SKIP : PH_TLV_HDR;

  assign room      = (pc_inc <= plen_r) ? plen_r - pc_inc : '0;
  assign tlv_body  = wa_shift - TLV_HDR_BYTES;
  assign tlvh_bad  = (wa_shift < TLV_HDR_BYTES) || (pc_inc > plen_r) ||
                     (tlv_body > 32'(room));
  assign tlvh_zero = (tlv_body == 32'd0);

  assign pay_rem_dec = (remain_r != 32'd0) ? remain_r - 32'd1 : remain_r;
  assign pay_fin     = (pay_rem_dec == 32'd0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HEADER: begin
        priority if (!hdr_word_done) phase_nxt = PH_HEADER;
        else if (hwc_r == HDR_LENGTH && len_bad) phase_nxt = PH_HUNT;
        else if (hwc_r == HDR_LAST) phase_nxt = end_hit ? PH_HUNT : begin_phase;
        else phase_nxt = PH_HEADER;
      end
      PH_TLV_HDR: begin
        priority if (end_hit) phase_nxt = PH_HUNT;
        else if (hwc_r != TLV_LEN_LAST) phase_nxt = PH_TLV_HDR;
        else if (tlvh_bad) phase_nxt = PH_SKIP;
        else if (tlvh_zero) phase_nxt = begin_phase;
        else phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        priority if (end_hit) phase_nxt = PH_HUNT;
        else if (pay_fin) phase_nxt = begin_phase;
        else phase_nxt = PH_PAYLOAD;
      end
      PH_SKIP: begin
        phase_nxt = end_hit ? PH_HUNT : PH_SKIP;
      end
      default: begin
        phase_nxt = sync_hit ? PH_HEADER : PH_HUNT;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    logic hunt_now;
    hunt_now   = 1'b0;
    recent_nxt = recent_r;
    pcount_nxt = pcount_r;
    plen_nxt   = plen_r;
    wasm_nxt   = wasm_r;
    hwc_nxt    = hwc_r;
    total_nxt  = total_r;
    cnt_nxt    = cnt_r;
    cls_nxt    = cls_r;
    remain_nxt = remain_r;
    err_nxt    = err_r;
    res_v      = 1'b0;
    res        = '0;

    unique case (phase_r)
      PH_HEADER: begin
        pcount_nxt = pc_inc;
        wasm_nxt   = wa_shift;
        if (hdr_word_done) begin
          res_v            = 1'b1;
          res.kind         = KIND_HDR;
          res.value        = wa_shift;
          res.header_field = hwc_r;
          priority if (hwc_r == HDR_LENGTH && len_bad) begin
            res.packet_end = 1'b1;
            res.status     = ST_BAD_LEN;
            hunt_now       = 1'b1;
          end else if (hwc_r == HDR_LAST) begin
            hwc_nxt  = 3'd0;
            wasm_nxt = 32'd0;
            if (begin_overrun) begin
              err_nxt = ST_HDR_OVR;
            end
            if (end_hit) begin
              res.packet_end = 1'b1;
              res.status     = err_nxt;
              hunt_now       = 1'b1;
            end
          end else begin
            if (hwc_r == HDR_LENGTH) begin
              plen_nxt = wa_shift[LW-1:0];
            end
            if (hwc_r == HDR_TLVS) begin
              total_nxt = wa_shift;
            end
            hwc_nxt = hwc_r + 3'd1;
          end
        end
      end
      PH_TLV_HDR: begin
        pcount_nxt = pc_inc;
        wasm_nxt   = wa_shift;
        priority if (hwc_r == TLV_TYPE_LAST) begin
          cls_nxt = classify(wa_shift);
          hwc_nxt = hwc_r + 3'd1;
        end else if (hwc_r == TLV_LEN_LAST) begin
          if (tlvh_bad) begin
            err_nxt = ST_PAY_OVR;
          end else begin
            remain_nxt = tlv_body;
            wasm_nxt   = 32'd0;
            if (tlvh_zero) begin
              cnt_nxt = cnt_inc;
              hwc_nxt = 3'd0;
              if (begin_overrun) begin
                err_nxt = ST_HDR_OVR;
              end
            end
          end
        end else begin
          hwc_nxt = hwc_r + 3'd1;
        end
        if (end_hit) begin
          res_v          = 1'b1;
          res.kind       = KIND_END;
          res.packet_end = 1'b1;
          res.status     = err_nxt;
          hunt_now       = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        pcount_nxt         = pc_inc;
        res_v              = 1'b1;
        res.kind           = KIND_PAY;
        res.value          = {24'd0, byte_data};
        res.tlv_class      = cls_r;
        res.tlv_number     = 8'(cnt_r);
        res.payload_offset = wasm_r[15:0];
        res.last_of_tlv    = (remain_r <= 32'd1);
        wasm_nxt           = wasm_r + 32'd1;
        remain_nxt         = pay_rem_dec;
        if (pay_fin) begin
          cnt_nxt  = cnt_inc;
          hwc_nxt  = 3'd0;
          wasm_nxt = 32'd0;
          if (begin_overrun) begin
            err_nxt = ST_HDR_OVR;
          end
        end
        if (end_hit) begin
          res.packet_end = 1'b1;
          res.status     = err_nxt;
          hunt_now       = 1'b1;
        end
      end
      PH_SKIP: begin
        pcount_nxt = pc_inc;
        if (end_hit) begin
          res_v          = 1'b1;
          res.kind       = KIND_END;
          res.packet_end = 1'b1;
          res.status     = err_nxt;
          hunt_now       = 1'b1;
        end
      end
      default: begin
        recent_nxt = recent_shift;
        pcount_nxt = hunt_cnt;
        if (sync_hit) begin
          pcount_nxt = LW'(8);
          plen_nxt   = '0;
          wasm_nxt   = 32'd0;
          hwc_nxt    = 3'd0;
          total_nxt  = 32'd0;
          cnt_nxt    = '0;
          cls_nxt    = CLS_POINT_CLOUD;
          remain_nxt = 32'd0;
          err_nxt    = ST_OK;
        end
      end
    endcase

    if (hunt_now) begin
      pcount_nxt = '0;
      recent_nxt = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      recent_r <= 64'd0;
      pcount_r <= '0;
      plen_r   <= '0;
      wasm_r   <= 32'd0;
      hwc_r    <= 3'd0;
      total_r  <= 32'd0;
      cnt_r    <= '0;
      cls_r    <= CLS_POINT_CLOUD;
      remain_r <= 32'd0;
      err_r    <= ST_OK;
    end else if (step) begin
      phase_r  <= phase_nxt;
      recent_r <= recent_nxt;
      pcount_r <= pcount_nxt;
      plen_r   <= plen_nxt;
      wasm_r   <= wasm_nxt;
      hwc_r    <= hwc_nxt;
      total_r  <= total_nxt;
      cnt_r    <= cnt_nxt;
      cls_r    <= cls_nxt;
      remain_r <= remain_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tlvd_checker.sv @@
// Port-level checks for the deframer and their bind to the top level.
`default_nettype none

module tlvd_checker
  import tlvd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [31:0] out_value,
  input wire logic [15:0] out_payload_offset,
  input wire logic        out_last_of_tlv,
  input wire logic        out_packet_end,
  input wire logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
    else $error("result changed while stalled");

  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_packet_end && out_value == 32'd0)
    else $error("end-only result without packet end");

  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_end |-> out_status == ST_OK)
    else $error("status set on a result that does not close a packet");

  a_pay_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAY |-> !out_last_of_tlv && out_payload_offset == 16'd0)
    else $error("payload tags on a non-payload result");

endmodule

bind radar_tlv_packet_deframer tlvd_checker u_tlvd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_value          (out_value),
  .out_payload_offset (out_payload_offset),
  .out_last_of_tlv    (out_last_of_tlv),
  .out_packet_end     (out_packet_end),
  .out_status         (out_status)
);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the radar TLV packet deframer: random packets vs. a predictor.
`default_nettype none

module tb;
  import tlvd_pkg::*;

  localparam logic [3:0] ADDR_SYNC    = {REG_SYNC, 3'b000};
  localparam logic [3:0] ADDR_MAX_LEN = {REG_MAX_LEN, 3'b000};
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 60;

  typedef enum int {FL_NONE, FL_LEN, FL_COUNT, FL_SHORT, FL_OVER, FL_CUT} flaw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [31:0] out_value;
  logic [2:0] out_header_field;
  logic [2:0] out_tlv_class;
  logic [7:0] out_tlv_number;
  logic [15:0] out_payload_offset;
  logic out_last_of_tlv;
  logic out_packet_end;
  logic [1:0] out_status;

  radar_tlv_packet_deframer u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_value(out_value),
    .out_header_field(out_header_field),
    .out_tlv_class(out_tlv_class),
    .out_tlv_number(out_tlv_number),
    .out_payload_offset(out_payload_offset),
    .out_last_of_tlv(out_last_of_tlv),
    .out_packet_end(out_packet_end),
    .out_status(out_status)
  );

  always #10 clk = ~clk;

  logic [7:0] rx_bytes_q[$];
  res_t expected_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int queued_bytes = 0;

  // deframer shadow state
  logic [63:0] sync_cfg = SYNC_WORD_RST;
  logic [15:0] max_len_cfg = MAX_LEN_RST;
  logic [63:0] recent = '0;
  phase_t ph = PH_HUNT;
  logic [15:0] pkt_cnt = '0;
  logic [15:0] pkt_len = '0;
  logic [31:0] word = '0;
  logic [2:0] hdr_idx = '0;
  logic [31:0] tlvs_total = '0;
  logic [7:0] tlv_idx = '0;
  tlv_class_t cur_cls = CLS_POINT_CLOUD;
  logic [31:0] tlv_left = '0;
  status_t pkt_err = ST_OK;

  function automatic tlv_class_t class_of(input logic [31:0] t);
    case (t)
      TYPE_POINT_CLOUD: return CLS_POINT_CLOUD;
      TYPE_OBJ_LIST: return CLS_OBJ_LIST;
      TYPE_INDEX: return CLS_INDEX;
      TYPE_PRESENCE: return CLS_PRESENCE;
      default: return CLS_UNKNOWN;
    endcase
  endfunction

  task restart_hunt;
    ph = PH_HUNT;
    pkt_cnt = '0;
    recent = '0;
  endtask

  task open_tlv;
    hdr_idx = '0;
    word = '0;
    if ({24'd0, tlv_idx} == tlvs_total) begin
      ph = PH_SKIP;
    end else if ({16'd0, pkt_cnt} + TLV_HDR_BYTES > {16'd0, pkt_len}) begin
      pkt_err = ST_HDR_OVR;
      ph = PH_SKIP;
    end else begin
      ph = PH_TLV_HDR;
    end
  endtask

  task close_tlv;
    if (tlv_idx != 8'hFF) tlv_idx++;
    open_tlv();
  endtask

  // advance the shadow deframer by one byte; queue the result it produces
  task deframe_byte(input logic [7:0] b);
    res_t r;
    bit got;
    bit at_end_check;
    logic [31:0] room;
    r = '0;
    got = 1'b0;
    at_end_check = 1'b0;
    case (ph)
      PH_HEADER: begin
        pkt_cnt = pkt_cnt + 16'd1;
        word = {b, word[31:8]};
        if (pkt_cnt[1:0] == 2'd0) begin
          got = 1'b1;
          r.kind = KIND_HDR;
          r.value = word;
          r.header_field = hdr_idx;
          if (hdr_idx == HDR_LENGTH &&
              (word < MIN_PACKET || word > {16'd0, max_len_cfg})) begin
            r.packet_end = 1'b1;
            r.status = ST_BAD_LEN;
            restart_hunt();
          end else begin
            if (hdr_idx == HDR_LENGTH) pkt_len = word[15:0];
            else if (hdr_idx == HDR_TLVS) tlvs_total = word;
            if (hdr_idx == HDR_LAST) begin
              open_tlv();
              at_end_check = 1'b1;
            end else begin
              hdr_idx++;
            end
          end
        end
      end
      PH_TLV_HDR: begin
        pkt_cnt = pkt_cnt + 16'd1;
        word = {b, word[31:8]};
        if (hdr_idx == TLV_TYPE_LAST) begin
          cur_cls = class_of(word);
          hdr_idx++;
        end else if (hdr_idx == TLV_LEN_LAST) begin
          room = (pkt_cnt <= pkt_len) ? {16'd0, pkt_len - pkt_cnt} : 32'd0;
          if (word < TLV_HDR_BYTES || pkt_cnt > pkt_len || word - TLV_HDR_BYTES > room) begin
            pkt_err = ST_PAY_OVR;
            ph = PH_SKIP;
          end else begin
            tlv_left = word - TLV_HDR_BYTES;
            word = '0;
            if (tlv_left == 0) close_tlv();
            else ph = PH_PAYLOAD;
          end
        end else begin
          hdr_idx++;
        end
        at_end_check = 1'b1;
      end
      PH_PAYLOAD: begin
        pkt_cnt = pkt_cnt + 16'd1;
        got = 1'b1;
        r.kind = KIND_PAY;
        r.value = {24'd0, b};
        r.tlv_class = cur_cls;
        r.tlv_number = tlv_idx;
        r.payload_offset = word[15:0];
        r.last_of_tlv = (tlv_left <= 1);
        word = word + 32'd1;
        if (tlv_left != 0) tlv_left--;
        if (tlv_left == 0) close_tlv();
        at_end_check = 1'b1;
      end
      PH_SKIP: begin
        pkt_cnt = pkt_cnt + 16'd1;
        at_end_check = 1'b1;
      end
      default: begin
        recent = {b, recent[63:8]};
        if (pkt_cnt < 16'd8) pkt_cnt++;
        if (pkt_cnt >= 16'd8 && recent == sync_cfg) begin
          ph = PH_HEADER;
          pkt_cnt = 16'd8;
          pkt_len = '0;
          word = '0;
          hdr_idx = '0;
          tlvs_total = '0;
          tlv_idx = '0;
          cur_cls = CLS_POINT_CLOUD;
          tlv_left = '0;
          pkt_err = ST_OK;
        end else begin
          ph = PH_HUNT;
        end
      end
    endcase
    if (at_end_check && pkt_cnt >= pkt_len) begin
      if (!got) begin
        got = 1'b1;
        r = '0;
        r.kind = KIND_END;
      end
      r.packet_end = 1'b1;
      r.status = pkt_err;
      restart_hunt();
    end
    if (got) expected_q.push_back(r);
  endtask

  task report_mismatch(input string what, input logic [31:0] got_v, input logic [31:0] want_v);
    if (mismatches < 200)
      $display("ERROR result %0d %s: got %h, expected %h", results_seen, what, got_v, want_v);
    mismatches++;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer, value", out_value, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", 32'(out_kind), 32'(want.kind));
          if (out_value !== want.value) report_mismatch("value", out_value, want.value);
          if (out_header_field !== want.header_field)
            report_mismatch("header_field", 32'(out_header_field), 32'(want.header_field));
          if (out_tlv_class !== want.tlv_class)
            report_mismatch("tlv_class", 32'(out_tlv_class), 32'(want.tlv_class));
          if (out_tlv_number !== want.tlv_number)
            report_mismatch("tlv_number", 32'(out_tlv_number), 32'(want.tlv_number));
          if (out_payload_offset !== want.payload_offset)
            report_mismatch("payload_offset", 32'(out_payload_offset),
                            32'(want.payload_offset));
          if (out_last_of_tlv !== want.last_of_tlv)
            report_mismatch("last_of_tlv", 32'(out_last_of_tlv), 32'(want.last_of_tlv));
          if (out_packet_end !== want.packet_end)
            report_mismatch("packet_end", 32'(out_packet_end), 32'(want.packet_end));
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
        end
        results_seen++;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task cfg_write(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task set_config(input logic [63:0] sync, input logic [15:0] max_len);
    cfg_write(ADDR_SYNC, sync);
    cfg_write(ADDR_MAX_LEN, {48'd0, max_len});
    sync_cfg = sync;
    max_len_cfg = max_len;
  endtask

  task automatic append_word(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
  endtask

  task automatic queue_bytes(ref logic [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) rx_bytes_q.push_back(q[i]);
    queued_bytes += n;
  endtask

  function automatic logic [31:0] pick_type();
    case ($urandom_range(4))
      0: return TYPE_POINT_CLOUD;
      1: return TYPE_OBJ_LIST;
      2: return TYPE_INDEX;
      3: return TYPE_PRESENCE;
      default: return $urandom();
    endcase
  endfunction

  // one packet, optionally with a flaw; pad < 0 picks random trailing filler
  task automatic gen_packet(input int ntlv, input int maxpay, input flaw_t flaw, input int pad);
    logic [7:0] pkt[$];
    int pay[];
    int victim;
    int keep;
    logic [31:0] total;
    logic [31:0] ann;
    logic [31:0] tlen;
    pay = new[ntlv];
    if (pad < 0) pad = ($urandom_range(3) == 0) ? $urandom_range(11) : 0;
    total = MIN_PACKET + pad;
    foreach (pay[i]) begin
      pay[i] = $urandom_range(maxpay);
      total += TLV_HDR_BYTES + pay[i];
    end
    ann = ntlv;
    victim = (ntlv == 0) ? -1 : $urandom_range(ntlv - 1);
    if (flaw == FL_LEN) begin
      case ($urandom_range(2))
        0: total = $urandom_range(39);
        1: total = {16'd0, max_len_cfg} + 32'd1 + $urandom_range(40);
        default: total = $urandom();
      endcase
    end
    if (flaw == FL_COUNT)
      ann = (ntlv != 0 && $urandom_range(1) == 1) ? $urandom_range(ntlv - 1)
                                                 : ntlv + 1 + $urandom_range(2);
    append_word(pkt, sync_cfg[31:0]);
    append_word(pkt, sync_cfg[63:32]);
    append_word(pkt, $urandom());
    append_word(pkt, total);
    append_word(pkt, $urandom());
    append_word(pkt, $urandom());
    append_word(pkt, $urandom());
    append_word(pkt, $urandom());
    append_word(pkt, ann);
    append_word(pkt, $urandom());
    foreach (pay[i]) begin
      tlen = TLV_HDR_BYTES + pay[i];
      if (i == victim && flaw == FL_SHORT) tlen = $urandom_range(7);
      if (i == victim && flaw == FL_OVER) tlen += 1 + $urandom_range(40);
      append_word(pkt, pick_type());
      append_word(pkt, tlen);
      repeat (pay[i]) pkt.push_back(8'($urandom_range(255)));
    end
    repeat (pad) pkt.push_back(8'($urandom_range(255)));
    keep = (flaw == FL_CUT) ? $urandom_range(8, pkt.size() - 1) : pkt.size();
    queue_bytes(pkt, keep);
  endtask

  // line noise, sometimes starting with a broken sync
  task automatic gen_noise();
    logic [7:0] junk[$];
    int k;
    if ($urandom_range(1) == 1) begin
      k = $urandom_range(1, 7);
      for (int i = 0; i < k; i++) junk.push_back(sync_cfg[8*i +: 8]);
    end
    repeat ($urandom_range(1, 6)) junk.push_back(8'($urandom_range(255)));
    queue_bytes(junk, junk.size());
  endtask

  task drain;
    do @(negedge clk); while (rx_bytes_q.size() != 0 || in_valid);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int start;
    flaw_t flaw;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_config(SYNC_WORD_RST, MAX_LEN_RST);
    @(negedge clk);
    gen_packet(0, 0, FL_NONE, 0);
    gen_packet(0, 0, FL_COUNT, 0);
    gen_packet(1, 4, FL_LEN, 0);
    gen_packet(1, 0, FL_NONE, 0);
    gen_packet(2, 6, FL_SHORT, 0);
    gen_packet(1, 6, FL_OVER, 0);
    gen_packet(1, 3, FL_COUNT, 5);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(SYNC_WORD_RST, MAX_LEN_RST);
        1: set_config(64'd0, 16'd40);
        2: set_config({64{1'b1}}, 16'hFFFF);
        3: set_config({$urandom(), $urandom()}, 16'($urandom_range(60, 300)));
        4: set_config({$urandom(), $urandom()}, 16'hFFFF);
        5: set_config(SYNC_WORD_RST, 16'd48);
        6: set_config({$urandom(), $urandom()}, 16'($urandom_range(40, 65535)));
        default: set_config(SYNC_WORD_RST, MAX_LEN_RST);
      endcase
      @(negedge clk);
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 84; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 84; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      start = queued_bytes;
      while (queued_bytes - start < PHASE_BYTES) begin
        if ($urandom_range(9) == 0) gen_noise();
        flaw = ($urandom_range(99) < 70) ? FL_NONE : flaw_t'($urandom_range(1, 5));
        gen_packet($urandom_range(3), ($urandom_range(7) == 0) ? 40 : 12, flaw, -1);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
